>>> src/nnm_pkg.sv
// nnm_pkg: shared types and constants of the nearest-neighbor mask block.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package nnm_pkg;

    // fixed field widths of the channels
    localparam int COORD_W      = 16;
    localparam int INDEX_OUT_W  = 4;
    localparam int MASK_OUT_W   = 16;
    localparam int COUNT_OUT_W  = 4;

    // configuration port
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 33;
    localparam int NCOUNT_W     = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEARCH_MODE     = 2'd0,
        CFG_NEIGHBOR_COUNT  = 2'd1,
        CFG_CAP_DISTANCE_SQ = 2'd2,
        CFG_RADIUS_SQ       = 2'd3
    } nnm_cfg_index_t;

    localparam logic                  RST_SEARCH_MODE     = 1'b0;
    localparam logic [NCOUNT_W-1:0]   RST_NEIGHBOR_COUNT  = 3'd2;
    localparam logic [CFG_DATA_W-1:0] RST_CAP_DISTANCE_SQ = 33'd376996;   // 614^2
    localparam logic [CFG_DATA_W-1:0] RST_RADIUS_SQ       = 33'd10738729; // 3277^2

    // distance pipeline: read, abs diff, square, sum
    localparam int PIPE_DEPTH = 4;
    localparam int DRAIN_W    = $clog2(PIPE_DEPTH);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } nnm_state_t;

endpackage

>>> src/nnm_if.sv
// nnm_if: valid/ready channel interfaces for point words and result words.
// Depends on nnm_pkg for the field widths.
`timescale 1ns / 1ps

interface nnm_point_if;
    import nnm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last_point;

    modport source (output valid, output pos_x, output pos_z, output last_point,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_z, input last_point,
                    output ready);
endinterface

interface nnm_result_if;
    import nnm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INDEX_OUT_W-1:0] point_index;
    logic [MASK_OUT_W-1:0]  neighbor_mask;
    logic [COUNT_OUT_W-1:0] found_count;
    logic                   last_result;

    modport source (output valid, output point_index, output neighbor_mask,
                    output found_count, output last_result, input ready);
    modport sink   (input valid, input point_index, input neighbor_mask,
                    input found_count, input last_result, output ready);
endinterface

>>> src/nearest_neighbor_mask.sv
// nearest_neighbor_mask: top level; point loading, per-point sweep sequencer,
// slot chain, radius mask and result register. Depends on nnm_pkg, nnm_if,
// nnm_dist and nnm_cell.
//
//   channel     | dir | word                                              | handshake
//   point_in    | in  | pos_x, pos_z, last_point                          | valid/ready
//   result_out  | out | point_index, neighbor_mask, found_count, last_res. | valid/ready
//   cfg         | in  | cfg_index, cfg_data                               | cfg_we
//
// After the last point word, each stored point is swept in turn: one candidate
// read per cycle through the distance pipeline, a drain of the pipeline, then
// the result is posted. point_in is ready only while loading. A stalled
// result_out holds the sweep at the post cycle. Reset clears control state and
// loads the register defaults; the point store needs no clearing.
`timescale 1ns / 1ps

module nearest_neighbor_mask #(
    parameter int NUM_POINTS    = 16,
    parameter int MAX_NEIGHBORS = 4,
    parameter int COORD_BITS    = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    nnm_point_if.sink                        point_in,
    nnm_result_if.source                     result_out,
    input  logic                             cfg_we,
    input  logic [nnm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nnm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nnm_pkg::*;

    localparam int IW    = $clog2(NUM_POINTS);
    localparam int CNT_W = $clog2(NUM_POINTS + 1);
    localparam int DW    = 2 * COORD_BITS + 1;
    localparam int SW    = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam int PW    = (IW > INDEX_OUT_W) ? IW : INDEX_OUT_W;
    localparam int MW    = (NUM_POINTS > MASK_OUT_W) ? NUM_POINTS : MASK_OUT_W;

    function automatic logic [COUNT_OUT_W-1:0] count_ones(logic [MASK_OUT_W-1:0] m);
        logic [COUNT_OUT_W:0] c;
        c = '0;
        for (int b = 0; b < MASK_OUT_W; b++)
            c = c + (COUNT_OUT_W+1)'(m[b]);
        return c[COUNT_OUT_W-1:0];
    endfunction

    // configuration registers
    logic                  search_mode_reg;
    logic [NCOUNT_W-1:0]   neighbor_count_reg;
    logic [CFG_DATA_W-1:0] cap_distance_sq_reg;
    logic [CFG_DATA_W-1:0] radius_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg     <= RST_SEARCH_MODE;
            neighbor_count_reg  <= RST_NEIGHBOR_COUNT;
            cap_distance_sq_reg <= RST_CAP_DISTANCE_SQ;
            radius_sq_reg       <= RST_RADIUS_SQ;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEARCH_MODE:     search_mode_reg     <= cfg_data[0];
                CFG_NEIGHBOR_COUNT:  neighbor_count_reg  <= cfg_data[NCOUNT_W-1:0];
                CFG_CAP_DISTANCE_SQ: cap_distance_sq_reg <= cfg_data;
                CFG_RADIUS_SQ:       radius_sq_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    // input coordinates, sign-extended from COORD_BITS by the distance math
    logic [COORD_BITS-1:0] x_coord, z_coord;

    if (COORD_BITS <= COORD_W)
    begin : g_coord_narrow
        assign x_coord = point_in.pos_x[COORD_BITS-1:0];
        assign z_coord = point_in.pos_z[COORD_BITS-1:0];
    end
    else
    begin : g_coord_wide
        assign x_coord = {{(COORD_BITS-COORD_W){1'b0}}, point_in.pos_x};
        assign z_coord = {{(COORD_BITS-COORD_W){1'b0}}, point_in.pos_z};
    end

    // sequencer
    nnm_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [IW-1:0]        self_reg, self_next;
    logic [IW-1:0]        cand_reg, cand_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;

    logic in_acc, store, cand_last, self_last, out_free, post, clear;

    assign point_in.ready = (state_reg == ST_LOAD);
    assign in_acc    = point_in.valid && point_in.ready;
    assign store     = in_acc && (count_reg < CNT_W'(NUM_POINTS));
    assign cand_last = (CNT_W'(cand_reg) + CNT_W'(1)) == total_reg;
    assign self_last = (CNT_W'(self_reg) + CNT_W'(1)) == total_reg;
    assign out_free  = !result_out.valid || result_out.ready;
    assign post      = (state_reg == ST_EMIT) && out_free;
    assign clear     = (in_acc && point_in.last_point) || (post && !self_last);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        self_next  = self_reg;
        cand_next  = cand_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (store)
                    count_next = count_reg + CNT_W'(1);
                if (in_acc && point_in.last_point)
                begin
                    total_next = store ? (count_reg + CNT_W'(1)) : count_reg;
                    count_next = '0;
                    self_next  = '0;
                    cand_next  = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cand_next = cand_reg + IW'(1);
                if (cand_last)
                begin
                    drain_next = DRAIN_W'(PIPE_DEPTH - 1);
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - DRAIN_W'(1);
                if (drain_reg == '0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (post)
                begin
                    if (self_last)
                        state_next = ST_LOAD;
                    else
                    begin
                        self_next  = self_reg + IW'(1);
                        cand_next  = '0;
                        state_next = ST_SWEEP;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            total_reg <= '0;
            self_reg  <= '0;
            cand_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            self_reg  <= self_next;
            cand_reg  <= cand_next;
            drain_reg <= drain_next;
        end
    end

    // distance pipeline
    logic            d_valid;
    logic [IW-1:0]   d_idx;
    logic [DW-1:0]   d_value;
    logic [SW-1:0]   d_wide;

    nnm_dist #(
        .NUM_POINTS (NUM_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (store),
        .wr_addr  (count_reg[IW-1:0]),
        .wr_x     (x_coord),
        .wr_z     (z_coord),
        .rd_valid ((state_reg == ST_SWEEP) && (cand_reg != self_reg)),
        .rd_self  (self_reg),
        .rd_cand  (cand_reg),
        .d_valid  (d_valid),
        .d_idx    (d_idx),
        .d_value  (d_value)
    );

    assign d_wide = SW'(d_value);

    // k-nearest slot chain
    logic [SW-1:0]            slot_dist  [MAX_NEIGHBORS];
    logic [IW-1:0]            slot_idx   [MAX_NEIGHBORS];
    logic                     slot_valid [MAX_NEIGHBORS];
    logic                     slot_less  [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] slot_active;

    for (genvar t = 0; t < MAX_NEIGHBORS; t++)
    begin : g_slot
        assign slot_active[t] = 32'(neighbor_count_reg) > 32'(t);

        if (t == 0)
        begin : g_head
            nnm_cell #(.SW(SW), .IW(IW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (clear),
                .cap        (SW'(cap_distance_sq_reg)),
                .cand_valid (d_valid),
                .cand_dist  (d_wide),
                .cand_idx   (d_idx),
                .prev_less  (1'b0),
                .prev_dist  ('0),
                .prev_idx   ('0),
                .prev_valid (1'b0),
                .cur_dist   (slot_dist[t]),
                .idx        (slot_idx[t]),
                .slot_valid (slot_valid[t]),
                .less       (slot_less[t])
            );
        end
        else
        begin : g_link
            nnm_cell #(.SW(SW), .IW(IW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (clear),
                .cap        (SW'(cap_distance_sq_reg)),
                .cand_valid (d_valid),
                .cand_dist  (d_wide),
                .cand_idx   (d_idx),
                .prev_less  (slot_less[t-1]),
                .prev_dist  (slot_dist[t-1]),
                .prev_idx   (slot_idx[t-1]),
                .prev_valid (slot_valid[t-1]),
                .cur_dist   (slot_dist[t]),
                .idx        (slot_idx[t]),
                .slot_valid (slot_valid[t]),
                .less       (slot_less[t])
            );
        end
    end

    logic [NUM_POINTS-1:0] knn_mask;

    always_comb
    begin
        knn_mask = '0;
        for (int t = 0; t < MAX_NEIGHBORS; t++)
            if (slot_valid[t] && slot_active[t])
                knn_mask[slot_idx[t]] = 1'b1;
    end

    // radius mode mask, built as distances arrive
    logic [NUM_POINTS-1:0] rmask_reg, rmask_next;

    always_comb
    begin
        rmask_next = rmask_reg;
        if (clear)
            rmask_next = '0;
        else if (d_valid && (d_wide < SW'(radius_sq_reg)))
            rmask_next[d_idx] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        rmask_reg <= rmask_next;
    end

    // result register
    logic [NUM_POINTS-1:0]  res_mask;
    logic [MW-1:0]          res_wide;
    logic [PW-1:0]          self_wide;
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_OUT_W-1:0] out_index_reg;
    logic [MASK_OUT_W-1:0]  out_mask_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_last_reg;

    assign res_mask  = search_mode_reg ? rmask_reg : knn_mask;
    assign res_wide  = MW'(res_mask);
    assign self_wide = PW'(self_reg);

    always_comb
    begin
        if (post)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (post)
        begin
            out_index_reg <= self_wide[INDEX_OUT_W-1:0];
            out_mask_reg  <= res_wide[MASK_OUT_W-1:0];
            out_count_reg <= count_ones(res_wide[MASK_OUT_W-1:0]);
            out_last_reg  <= self_last;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.point_index   = out_index_reg;
    assign result_out.neighbor_mask = out_mask_reg;
    assign result_out.found_count   = out_count_reg;
    assign result_out.last_result   = out_last_reg;

endmodule

>>> src/nnm_dist.sv
// nnm_dist: point store and squared-distance pipeline (read, |d|, square, sum).
// Depends on nnm_pkg.
`timescale 1ns / 1ps

module nnm_dist #(
    parameter int NUM_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [$clog2(NUM_POINTS)-1:0]       wr_addr,
    input  logic [COORD_BITS-1:0]               wr_x,
    input  logic [COORD_BITS-1:0]               wr_z,
    input  logic                                rd_valid,
    input  logic [$clog2(NUM_POINTS)-1:0]       rd_self,
    input  logic [$clog2(NUM_POINTS)-1:0]       rd_cand,
    output logic                                d_valid,
    output logic [$clog2(NUM_POINTS)-1:0]       d_idx,
    output logic [2*COORD_BITS:0]               d_value
);
    import nnm_pkg::*;

    localparam int IW = $clog2(NUM_POINTS);
    localparam int CW = COORD_BITS;

    logic [CW-1:0] x_mem [NUM_POINTS];
    logic [CW-1:0] z_mem [NUM_POINTS];

    logic [CW-1:0]   xs_reg, zs_reg, xc_reg, zc_reg;
    logic [CW-1:0]   ax_reg, az_reg;
    logic [2*CW-1:0] sqx_reg, sqz_reg;
    logic [2*CW:0]   d_reg;
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [IW-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;

    logic [CW:0] dx, dz, adx, adz;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            z_mem[wr_addr] <= wr_z;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg <= x_mem[rd_self];
        zs_reg <= z_mem[rd_self];
        xc_reg <= x_mem[rd_cand];
        zc_reg <= z_mem[rd_cand];
    end

    // sign-extended difference, magnitude always fits CW bits
    assign dx  = {xs_reg[CW-1], xs_reg} - {xc_reg[CW-1], xc_reg};
    assign dz  = {zs_reg[CW-1], zs_reg} - {zc_reg[CW-1], zc_reg};
    assign adx = dx[CW] ? (~dx + 1'b1) : dx;
    assign adz = dz[CW] ? (~dz + 1'b1) : dz;

    always_ff @(posedge clk)
    begin
        ax_reg     <= adx[CW-1:0];
        az_reg     <= adz[CW-1:0];
        sqx_reg    <= ax_reg * ax_reg;
        sqz_reg    <= az_reg * az_reg;
        d_reg      <= {1'b0, sqx_reg} + {1'b0, sqz_reg};
        s1_idx_reg <= rd_cand;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        s4_idx_reg <= s3_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign d_valid = s4_valid_reg;
    assign d_idx   = s4_idx_reg;
    assign d_value = d_reg;

endmodule

>>> src/nnm_cell.sv
// nnm_cell: one slot of the sorted best-distance list; slots form a chain
// that shifts down on insertion. Depends on nnm_pkg.
`timescale 1ns / 1ps

module nnm_cell #(
    parameter int SW = 34,
    parameter int IW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic [SW-1:0] cap,
    input  logic          cand_valid,
    input  logic [SW-1:0] cand_dist,
    input  logic [IW-1:0] cand_idx,
    input  logic          prev_less,
    input  logic [SW-1:0] prev_dist,
    input  logic [IW-1:0] prev_idx,
    input  logic          prev_valid,
    output logic [SW-1:0] cur_dist,
    output logic [IW-1:0] idx,
    output logic          slot_valid,
    output logic          less
);
    import nnm_pkg::*;

    logic [SW-1:0] dist_reg, dist_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          valid_reg, valid_next;

    // strict compare: a tie leaves the earlier point ahead
    assign less = cand_dist < dist_reg;

    always_comb
    begin
        dist_next  = dist_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (clear)
        begin
            dist_next  = cap;
            valid_next = 1'b0;
        end
        else if (cand_valid && less)
        begin
            if (prev_less)
            begin
                dist_next  = prev_dist;
                idx_next   = prev_idx;
                valid_next = prev_valid;
            end
            else
            begin
                dist_next  = cand_dist;
                idx_next   = cand_idx;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign cur_dist   = dist_reg;
    assign idx        = idx_reg;
    assign slot_valid = valid_reg;

endmodule

>>> src/nnm_checker.sv
// nnm_checker: port-level assertions for nearest_neighbor_mask, bound to the
// top level. Depends on nnm_pkg.
`timescale 1ns / 1ps

module nnm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            in_last,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [nnm_pkg::INDEX_OUT_W-1:0] out_index,
    input logic [nnm_pkg::MASK_OUT_W-1:0]  out_mask,
    input logic [nnm_pkg::COUNT_OUT_W-1:0] out_count,
    input logic                            out_last
);
    import nnm_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mask)
            && $stable(out_index) && $stable(out_count) && $stable(out_last))
        else $error("result word changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count == COUNT_OUT_W'($countones(out_mask)))
        else $error("found_count does not match mask");

    a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_mask[out_index])
        else $error("point marked as its own neighbor");

    // the search starts right after the last point word
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("point input still ready after last word");

endmodule

bind nearest_neighbor_mask nnm_checker u_nnm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (point_in.valid),
    .in_ready  (point_in.ready),
    .in_last   (point_in.last_point),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_index (result_out.point_index),
    .out_mask  (result_out.neighbor_mask),
    .out_count (result_out.found_count),
    .out_last  (result_out.last_result)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for nearest_neighbor_mask. Sends point sets, predicts
// every neighbor mask word and checks the result channel word by word.
// Depends on nnm_pkg, nnm_if and the block RTL.

module tb_top;
    import nnm_pkg::*;

    localparam int NUM_PTS = 16;
    localparam int MAX_NBR = 4;
    localparam longint unsigned DIST_SQ_MAX = 64'd8589672450;   // 2 * 65535^2
    localparam int SETTLE_CYCLES = 2 * (NUM_PTS + PIPE_DEPTH + 1);
    localparam int RANDOM_POINTS = 270;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] idx;
        logic [MASK_OUT_W-1:0]  mask;
        logic [COUNT_OUT_W-1:0] cnt;
        logic                   last;
    } nbr_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    nnm_point_if  pt ();
    nnm_result_if rs ();

    nearest_neighbor_mask #(
        .NUM_POINTS    (NUM_PTS),
        .MAX_NEIGHBORS (MAX_NBR),
        .COORD_BITS    (COORD_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .point_in   (pt),
        .result_out (rs),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow of the block: settings and loaded points
    logic                      mode_q  = RST_SEARCH_MODE;
    logic [NCOUNT_W-1:0]       k_q     = RST_NEIGHBOR_COUNT;
    logic [CFG_DATA_W-1:0]     cap_q   = RST_CAP_DISTANCE_SQ;
    logic [CFG_DATA_W-1:0]     rad_q   = RST_RADIUS_SQ;
    logic signed [COORD_W-1:0] pt_x [NUM_PTS];
    logic signed [COORD_W-1:0] pt_z [NUM_PTS];
    int                        n_loaded = 0;

    nbr_word_t nbr_masks_due [$];
    int        mismatches = 0;
    bit        src_gaps = 1'b0;
    bit        sink_stalls = 1'b0;
    int        stall_left = 0;

    function automatic longint unsigned sq_distance(input int a, input int b);
        longint dx, dz;
        dx = longint'(pt_x[a]) - longint'(pt_x[b]);
        dz = longint'(pt_z[a]) - longint'(pt_z[b]);
        return longint'(dx * dx + dz * dz);
    endfunction

    // insertion list of the k closest; strict compare keeps the earlier point on a tie
    function automatic logic [MASK_OUT_W-1:0] k_nearest_mask(input int self, input int k);
        longint unsigned bd [MAX_NBR];
        int              bi [MAX_NBR];
        bit              bv [MAX_NBR];
        longint unsigned d, td;
        int              ti;
        bit              tv;
        logic [MASK_OUT_W-1:0] m;
        m = '0;
        if (k == 0)
            return m;
        for (int t = 0; t < k; t++)
        begin
            bd[t] = cap_q;
            bi[t] = 0;
            bv[t] = 1'b0;
        end
        for (int j = 0; j < n_loaded; j++)
        begin
            if (j == self)
                continue;
            d = sq_distance(self, j);
            if (d < bd[k-1])
            begin
                bd[k-1] = d;
                bi[k-1] = j;
                bv[k-1] = 1'b1;
                for (int t = k - 1; t > 0 && bd[t-1] > bd[t]; t--)
                begin
                    td = bd[t];   ti = bi[t];   tv = bv[t];
                    bd[t] = bd[t-1];   bi[t] = bi[t-1];   bv[t] = bv[t-1];
                    bd[t-1] = td;   bi[t-1] = ti;   bv[t-1] = tv;
                end
            end
        end
        // slots never filled mark nothing
        for (int t = 0; t < k; t++)
            if (bv[t])
                m[bi[t]] = 1'b1;
        return m;
    endfunction

    function automatic logic [MASK_OUT_W-1:0] within_radius_mask(input int self);
        logic [MASK_OUT_W-1:0] m;
        m = '0;
        for (int j = 0; j < n_loaded; j++)
            if (j != self && sq_distance(self, j) < rad_q)
                m[j] = 1'b1;
        return m;
    endfunction

    task automatic search_neighbors();
        nbr_word_t w;
        int        k;
        k = (k_q > MAX_NBR) ? MAX_NBR : int'(k_q);
        for (int i = 0; i < n_loaded; i++)
        begin
            w.idx  = INDEX_OUT_W'(i);
            w.mask = mode_q ? within_radius_mask(i) : k_nearest_mask(i, k);
            w.cnt  = COUNT_OUT_W'($countones(w.mask));
            w.last = (i == n_loaded - 1);
            nbr_masks_due.push_back(w);
        end
        n_loaded = 0;
    endtask

    // tracks settings, loads points, and checks every result word
    always @(posedge clk)
    begin : monitor
        nbr_word_t got, want;
        if (rst_n)
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_SEARCH_MODE:     mode_q = cfg_data[0];
                    CFG_NEIGHBOR_COUNT:  k_q    = cfg_data[NCOUNT_W-1:0];
                    CFG_CAP_DISTANCE_SQ: cap_q  = cfg_data;
                    CFG_RADIUS_SQ:       rad_q  = cfg_data;
                    default: ;
                endcase
            if (pt.valid === 1'b1 && pt.ready === 1'b1)
            begin
                // over capacity: word dropped, but a last flag still starts the search
                if (n_loaded < NUM_PTS)
                begin
                    pt_x[n_loaded] = pt.pos_x;
                    pt_z[n_loaded] = pt.pos_z;
                    n_loaded++;
                end
                if (pt.last_point)
                    search_neighbors();
            end
            if (rs.valid === 1'b1 && rs.ready === 1'b1)
            begin
                got.idx  = rs.point_index;
                got.mask = rs.neighbor_mask;
                got.cnt  = rs.found_count;
                got.last = rs.last_result;
                if (nbr_masks_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word idx=%0d mask=%h cnt=%0d last=%0b",
                                 $realtime, got.idx, got.mask, got.cnt, got.last);
                end
                else
                begin
                    want = nbr_masks_due.pop_front();
                    if (got.idx !== want.idx || got.mask !== want.mask ||
                        got.cnt !== want.cnt || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp idx=%0d mask=%h cnt=%0d last=%0b",
                                      " got idx=%0d mask=%h cnt=%0d last=%0b"}, $realtime,
                                     want.idx, want.mask, want.cnt, want.last,
                                     got.idx, got.mask, got.cnt, got.last);
                    end
                end
            end
        end
    end

    // result sink: random stall bursts on ready
    always @(posedge clk)
    begin
        if (!rst_n)
            rs.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            rs.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0)
        begin
            rs.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            rs.ready <= 1'b1;
    end

    // valid stays high across back-to-back words; it only drops for a gap
    task automatic send_point(input int x, input int z, input bit last);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            pt.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pt.valid      <= 1'b1;
        pt.pos_x      <= COORD_W'(x);
        pt.pos_z      <= COORD_W'(z);
        pt.last_point <= last;
        do
            @(posedge clk);
        while (pt.ready !== 1'b1);
    endtask

    task automatic wait_idle();
        pt.valid <= 1'b0;
        @(posedge clk);
        while (nbr_masks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input bit mode, input logic [NCOUNT_W-1:0] k,
                                 input longint unsigned cap, input longint unsigned rad);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEARCH_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= CFG_NEIGHBOR_COUNT;
        cfg_data  <= CFG_DATA_W'(k);
        @(posedge clk);
        cfg_index <= CFG_CAP_DISTANCE_SQ;
        cfg_data  <= CFG_DATA_W'(cap);
        @(posedge clk);
        cfg_index <= CFG_RADIUS_SQ;
        cfg_data  <= CFG_DATA_W'(rad);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // reset settings: one pair inside the cap, one pair exactly on it
    task automatic test_defaults();
        send_point(0, 0, 1'b0);
        send_point(613, 0, 1'b0);
        send_point(0, -614, 1'b1);
    endtask

    // corners of the coordinate range; the diagonal sits exactly on the max radius
    task automatic test_extremes();
        load_settings(1'b1, 3'd2, RST_CAP_DISTANCE_SQ, DIST_SQ_MAX);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, 32767, 1'b1);
    endtask

    task automatic test_ties();
        load_settings(1'b0, 3'd1, DIST_SQ_MAX, RST_RADIUS_SQ);
        send_point(0, 0, 1'b0);
        send_point(100, 0, 1'b0);
        send_point(-100, 0, 1'b0);
        send_point(0, 100, 1'b1);
    endtask

    task automatic test_k_zero();
        load_settings(1'b0, 3'd0, DIST_SQ_MAX, RST_RADIUS_SQ);
        send_point(5, 5, 1'b0);
        send_point(6, 6, 1'b1);
    endtask

    // k above the list depth saturates
    task automatic test_k_saturate();
        load_settings(1'b0, 3'd7, DIST_SQ_MAX, RST_RADIUS_SQ);
        for (int i = 0; i < 6; i++)
            send_point(i, 0, i == 5);
    endtask

    // far point leaves every slot empty; then a set of one point
    task automatic test_unfilled();
        load_settings(1'b0, 3'd4, RST_CAP_DISTANCE_SQ, RST_RADIUS_SQ);
        send_point(100, 100, 1'b0);
        send_point(100, 200, 1'b0);
        send_point(-30000, 5000, 1'b1);
        send_point(7, -7, 1'b1);
    endtask

    function automatic longint unsigned pick_dist_sq();
        longint unsigned s;
        case ($urandom_range(0, 5))
            0: return 0;
            1: return DIST_SQ_MAX;
            2: s = $urandom_range(0, 800);
            3: s = $urandom_range(0, 5000);
            default: s = $urandom_range(0, 65535);
        endcase
        return s * s * longint'($urandom_range(1, 2));
    endfunction

    // clustered sets hit the thresholds; grid offsets force equal distances
    task automatic send_cloud(input int size);
        int kind, cx, cz, spread, q, ox, oz;
        kind = $urandom_range(0, 3);
        cx = int'($urandom_range(0, 65535)) - 32768;
        cz = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 3))
            0: spread = 64;
            1: spread = 700;
            2: spread = 4000;
            default: spread = 32768;
        endcase
        q = spread / 4;
        for (int i = 0; i < size; i++)
        begin
            if (kind == 0)
                send_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                           i == size - 1);
            else
            begin
                ox = int'($urandom_range(0, 2 * spread)) - spread;
                oz = int'($urandom_range(0, 2 * spread)) - spread;
                if (kind == 1)
                begin
                    ox = (ox / q) * q;
                    oz = (oz / q) * q;
                end
                send_point(cx + ox, cz + oz, i == size - 1);
            end
        end
    endtask

    task automatic test_random_sets();
        int  stored, size, sets_done;
        bit  quiet;
        stored = 0;
        sets_done = 0;
        while (stored < RANDOM_POINTS)
        begin
            // no source gaps or sink stalls near the end of the run
            quiet = (RANDOM_POINTS - stored) < 50;
            src_gaps    = !quiet && ($urandom_range(0, 3) != 0);
            sink_stalls = !quiet && ($urandom_range(0, 3) != 0);
            load_settings(1'($urandom_range(0, 1)), NCOUNT_W'($urandom_range(0, 7)),
                          pick_dist_sq(), pick_dist_sq());
            repeat ($urandom_range(1, 3))
            begin
                if (sets_done == 0)
                    size = $urandom_range(NUM_PTS + 1, NUM_PTS + 4);
                else
                    case ($urandom_range(0, 9))
                        0: size = 1;
                        1: size = $urandom_range(NUM_PTS + 1, NUM_PTS + 4);
                        default: size = $urandom_range(2, NUM_PTS);
                    endcase
                send_cloud(size);
                stored += (size > NUM_PTS) ? NUM_PTS : size;
                sets_done++;
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_SEARCH_MODE;
        cfg_data      <= '0;
        pt.valid      <= 1'b0;
        pt.pos_x      <= '0;
        pt.pos_z      <= '0;
        pt.last_point <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        test_defaults();
        test_extremes();
        test_ties();
        test_k_zero();
        test_k_saturate();
        test_unfilled();
        test_random_sets();
        wait_idle();

        if (mismatches == 0 && nbr_masks_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
